[hw/rtl/unit_disk_graph_chromatic_number_macros.svh]
// Assertion macros for the RTL of the unit-disk graph colouring block.
`ifndef UNIT_DISK_GRAPH_CHROMATIC_NUMBER_MACROS_SVH
`define UNIT_DISK_GRAPH_CHROMATIC_NUMBER_MACROS_SVH
`ifndef SYNTH
`define UDGCN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("udgcn: same-cycle check failed");
`define UDGCN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("udgcn: next-cycle check failed");
`else
`define UDGCN_ASSERT_IMP(label, ante, cons)
`define UDGCN_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hw/rtl/udgcn_pkg.sv]
// Types and constants of the unit-disk graph colouring block.
package udgcn_pkg;

  localparam int COORD_W   = 24;
  localparam int THR_W     = 52;
  localparam int COST_W    = 5;
  localparam logic [THR_W-1:0] THR_RESET = 52'd802816;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_point;
  } udgcn_in_t;

  typedef struct packed {
    logic [COST_W-1:0] colour_count;
    logic              points_dropped;
  } udgcn_out_t;

endpackage

[hw/rtl/udgcn_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module udgcn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/unit_disk_graph_chromatic_number.sv]
// Top level of the unit-disk graph colouring block.
// Points are taken one per cycle and up to MAX_VERTICES are stored; a point marked
// last_point starts the computation, during which no input is taken. Every pair of
// stored points is then checked in turn: RDI, RDJ and CAPJ read and capture the two
// points, DIFF, SQ and ACC form difference, square and sum for each coordinate (one
// multiplier, one coordinate at a time) and CMP compares. A subset dynamic program
// follows over all 2^n - 1 subsets, with the costs held in a 2^MAX_VERTICES x 5 RAM:
// an independent subset is written in DPS alone, any other passes through DPS and
// DPB, then DPSUB for each submask of its candidate pool and DPRD for each independent
// part, since each cost read goes through the RAM's single read port. The result then
// waits in an output register while the next set of points is loaded. No clearing
// pass is needed after reset. The squared distance threshold may only be written
// while idle.
module unit_disk_graph_chromatic_number
  import udgcn_pkg::*;
#(
  parameter int MAX_VERTICES = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  udgcn_in_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output udgcn_out_t       out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data
);

  `include "unit_disk_graph_chromatic_number_macros.svh"

  localparam int PAW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNW = $clog2(MAX_VERTICES + 1);
  localparam int SW  = MAX_VERTICES;
  localparam int PW  = 3 * COORD_W;
  localparam int SQW = 2 * COORD_W + 2;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_SETUP = 14'b00000000000010,
    ST_RDI   = 14'b00000000000100,
    ST_RDJ   = 14'b00000000001000,
    ST_CAPJ  = 14'b00000000010000,
    ST_DIFF  = 14'b00000000100000,
    ST_SQ    = 14'b00000001000000,
    ST_ACC   = 14'b00000010000000,
    ST_CMP   = 14'b00000100000000,
    ST_DPS   = 14'b00001000000000,
    ST_DPB   = 14'b00010000000000,
    ST_DPSUB = 14'b00100000000000,
    ST_DPRD  = 14'b01000000000000,
    ST_DONE  = 14'b10000000000000
  } state_t;

  state_t            st_r, st_nxt;
  logic [THR_W-1:0]  thr_r, thr_nxt;
  logic [CNW-1:0]    cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              drop_r, drop_nxt;
  logic [CNW-1:0]    n_r, n_nxt;
  logic [CNW-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [1:0]        k_r, k_nxt;
  logic [PW-1:0]     pi_r, pi_nxt, pj_r, pj_nxt;
  logic [COORD_W:0]  ad_r, ad_nxt;
  logic [SQW-1:0]    sq_r, sq_nxt;
  logic [THR_W-1:0]  sum_r, sum_nxt;
  logic [SW-1:0]     adj_r [MAX_VERTICES];
  logic [SW-1:0]     adj_nxt [MAX_VERTICES];
  logic [SW-1:0]     s_r, s_nxt, full_r, full_nxt;
  logic [SW-1:0]     bit_r, bit_nxt, pool_r, pool_nxt, sub_r, sub_nxt;
  logic [COST_W-1:0] best_r, best_nxt, res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  udgcn_out_t        out_data_r, out_data_nxt;

  logic              in_fire;
  logic              room;
  logic [CNW-1:0]    cnt_after;
  logic              ovf_after;
  logic              pwe;
  logic [PAW-1:0]    prd_addr;
  logic [PW-1:0]     prd_data;
  logic              cwe;
  logic [COST_W-1:0] cwr_data;
  logic [SW-1:0]     crd_addr;
  logic [COST_W-1:0] crd_data;
  logic [COST_W-1:0] cand;
  logic [PAW-1:0]    lo_c;
  logic [SW-1:0]     bit_c;
  logic [SW-1:0]     part_c;
  logic              ind_s, ind_part;
  logic [SW:0]       full_w;
  logic signed [COORD_W:0] diff_c;
  logic [COORD_W-1:0] ca, cb;

  // A subset is independent when none of its members has a neighbour inside it.
  function automatic logic indep(input logic [SW-1:0] s, input logic [SW-1:0] rows [SW]);
    logic ok;
    ok = 1'b1;
    for (int v = 0; v < SW; v++) begin
      if (s[v] && ((rows[v] & s) != '0)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  function automatic logic [PAW-1:0] low_idx(input logic [SW-1:0] s);
    logic [PAW-1:0] lo;
    lo = '0;
    for (int v = SW - 1; v >= 0; v--) begin
      if (s[v]) begin
        lo = PAW'(v);
      end
    end
    return lo;
  endfunction

  udgcn_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_point_ram (
    .clk     (clk),
    .wr_en   (pwe),
    .wr_addr (cnt_r[PAW-1:0]),
    .wr_data ({in_data.coord_x, in_data.coord_y, in_data.coord_z}),
    .rd_addr (prd_addr),
    .rd_data (prd_data)
  );

  udgcn_ram #(.WIDTH(COST_W), .DEPTH(1 << MAX_VERTICES)) u_cost_ram (
    .clk     (clk),
    .wr_en   (cwe),
    .wr_addr (s_r),
    .wr_data (cwr_data),
    .rd_addr (crd_addr),
    .rd_data (crd_data)
  );

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign room      = (cnt_r < CNW'(MAX_VERTICES));
  assign cnt_after = room ? (cnt_r + CNW'(1)) : cnt_r;
  assign ovf_after = ovf_r || !room;
  assign pwe       = in_fire && room;
  assign prd_addr  = (st_r == ST_RDI) ? i_r[PAW-1:0] : j_r[PAW-1:0];

  assign lo_c     = low_idx(s_r);
  assign bit_c    = SW'(1) << lo_c;
  assign part_c   = sub_r | bit_r;
  assign ind_s    = indep(s_r, adj_r);
  assign ind_part = indep(part_c, adj_r);
  assign cand     = crd_data + COST_W'(1);
  assign full_w   = ((SW + 1)'(1) << n_r) - (SW + 1)'(1);

  assign ca     = pi_r[k_r * COORD_W +: COORD_W];
  assign cb     = pj_r[k_r * COORD_W +: COORD_W];
  assign diff_c = $signed({ca[COORD_W-1], ca}) - $signed({cb[COORD_W-1], cb});

  always_comb begin
    st_nxt        = st_r;
    thr_nxt       = cfg_valid ? cfg_data : thr_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    drop_nxt      = drop_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    pi_nxt        = pi_r;
    pj_nxt        = pj_r;
    ad_nxt        = ad_r;
    sq_nxt        = sq_r;
    sum_nxt       = sum_r;
    adj_nxt       = adj_r;
    s_nxt         = s_r;
    full_nxt      = full_r;
    bit_nxt       = bit_r;
    pool_nxt      = pool_r;
    sub_nxt       = sub_r;
    best_nxt      = best_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cwe           = 1'b0;
    cwr_data      = best_r;
    crd_addr      = s_r & ~bit_c;

    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt = cnt_after;
          ovf_nxt = ovf_after;
          if (in_data.last_point) begin
            drop_nxt = ovf_after;
            n_nxt    = cnt_after;
            for (int v = 0; v < SW; v++) begin
              adj_nxt[v] = '0;
            end
            if (cnt_after == '0) begin
              res_nxt = '0;
              st_nxt  = ST_DONE;
            end else begin
              st_nxt = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        full_nxt = full_w[SW-1:0];
        i_nxt    = '0;
        j_nxt    = CNW'(1);
        s_nxt    = SW'(1);
        st_nxt   = (n_r > CNW'(1)) ? ST_RDI : ST_DPS;
      end
      ST_RDI: begin
        st_nxt = ST_RDJ;
      end
      ST_RDJ: begin
        pi_nxt = prd_data;
        st_nxt = ST_CAPJ;
      end
      ST_CAPJ: begin
        pj_nxt  = prd_data;
        sum_nxt = '0;
        k_nxt   = '0;
        st_nxt  = ST_DIFF;
      end
      ST_DIFF: begin
        ad_nxt = diff_c[COORD_W] ? (COORD_W + 1)'(-diff_c) : (COORD_W + 1)'(diff_c);
        st_nxt = ST_SQ;
      end
      ST_SQ: begin
        sq_nxt = SQW'(ad_r) * SQW'(ad_r);
        st_nxt = ST_ACC;
      end
      ST_ACC: begin
        sum_nxt = sum_r + THR_W'(sq_r);
        if (k_r == 2'd2) begin
          st_nxt = ST_CMP;
        end else begin
          k_nxt  = k_r + 2'd1;
          st_nxt = ST_DIFF;
        end
      end
      ST_CMP: begin
        if (sum_r < thr_r) begin
          adj_nxt[i_r[PAW-1:0]][j_r[PAW-1:0]] = 1'b1;
          adj_nxt[j_r[PAW-1:0]][i_r[PAW-1:0]] = 1'b1;
        end
        if ((CNW + 1)'(j_r) + (CNW + 1)'(1) < (CNW + 1)'(n_r)) begin
          j_nxt  = j_r + CNW'(1);
          st_nxt = ST_RDI;
        end else if ((CNW + 1)'(i_r) + (CNW + 1)'(2) < (CNW + 1)'(n_r)) begin
          i_nxt  = i_r + CNW'(1);
          j_nxt  = i_r + CNW'(2);
          st_nxt = ST_RDI;
        end else begin
          st_nxt = ST_DPS;
        end
      end
      ST_DPS: begin
        if (ind_s) begin
          cwe      = 1'b1;
          cwr_data = COST_W'(1);
          if (s_r == full_r) begin
            res_nxt = COST_W'(1);
            st_nxt  = ST_DONE;
          end else begin
            s_nxt = s_r + SW'(1);
          end
        end else begin
          // Some colour class holds the lowest vertex; the base case takes it alone.
          bit_nxt  = bit_c;
          pool_nxt = s_r & ~bit_c & ~adj_r[lo_c];
          st_nxt   = ST_DPB;
        end
      end
      ST_DPB: begin
        best_nxt = cand;
        sub_nxt  = pool_r;
        st_nxt   = ST_DPSUB;
      end
      ST_DPSUB: begin
        crd_addr = s_r & ~part_c;
        if (sub_r == '0) begin
          cwe = 1'b1;
          if (s_r == full_r) begin
            res_nxt = best_r;
            st_nxt  = ST_DONE;
          end else begin
            s_nxt  = s_r + SW'(1);
            st_nxt = ST_DPS;
          end
        end else if (ind_part) begin
          st_nxt = ST_DPRD;
        end else begin
          sub_nxt = (sub_r - SW'(1)) & pool_r;
        end
      end
      ST_DPRD: begin
        if (cand < best_r) begin
          best_nxt = cand;
        end
        sub_nxt = (sub_r - SW'(1)) & pool_r;
        st_nxt  = ST_DPSUB;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.colour_count   = res_r;
          out_data_nxt.points_dropped = drop_r;
          cnt_nxt                     = '0;
          ovf_nxt                     = 1'b0;
          st_nxt                      = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      thr_r       <= THR_RESET;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      thr_r       <= thr_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drop_r     <= drop_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    pi_r       <= pi_nxt;
    pj_r       <= pj_nxt;
    ad_r       <= ad_nxt;
    sq_r       <= sq_nxt;
    sum_r      <= sum_nxt;
    adj_r      <= adj_nxt;
    s_r        <= s_nxt;
    full_r     <= full_nxt;
    bit_r      <= bit_nxt;
    pool_r     <= pool_nxt;
    sub_r      <= sub_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `UDGCN_ASSERT_NXT(a_count_step, in_valid && in_ready && !in_data.last_point && cnt_r < CNW'(MAX_VERTICES), cnt_r == $past(cnt_r) + CNW'(1))
  `UDGCN_ASSERT_IMP(a_part_in_subset, st_r == ST_DPSUB && sub_r != '0, (part_c & ~s_r) == '0)
  `UDGCN_ASSERT_IMP(a_dp_nonempty, st_r == ST_DPS || st_r == ST_DPSUB || st_r == ST_DPRD, s_r != '0)
  `UDGCN_ASSERT_NXT(a_result_loaded, st_r == ST_DONE && (!out_valid_r || out_ready), out_valid_r && cnt_r == '0)

endmodule

[test/tb_top.sv]
// Self-checking testbench for the unit-disk graph colouring block.
`timescale 1ns / 1ps

module tb_top;
  import udgcn_pkg::*;

  localparam int MAX_PTS   = 20;
  localparam int HOLD_LEN  = 3000;
  localparam logic [THR_W-1:0] THR_MAX = {THR_W{1'b1}};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  udgcn_in_t        in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  udgcn_out_t       out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data = '0;

  // Predictor state.
  longint            pt_x[MAX_PTS];
  longint            pt_y[MAX_PTS];
  longint            pt_z[MAX_PTS];
  int unsigned       pt_count = 0;
  bit                pts_lost = 1'b0;
  logic [THR_W-1:0]  join_thr = THR_RESET;
  udgcn_out_t        colour_q[$];

  int  err_count = 0;
  bit  hold_req = 1'b0;

  always #1 clk = ~clk;

  unit_disk_graph_chromatic_number i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned lowest_bit(int unsigned s);
    int unsigned i;
    i = 0;
    while (i < 31 && !s[i]) i++;
    return i;
  endfunction

  // Chromatic number of the stored points by subset dynamic programming.
  function automatic int unsigned min_colours(int unsigned n);
    int unsigned adj[MAX_PTS];
    bit          indep[];
    byte unsigned cost[];
    int unsigned full, s, lo, bit_lo, pool, sub, best, c, part;
    longint      dx, dy, dz;
    longint unsigned dsq;
    for (int i = 0; i < MAX_PTS; i++) adj[i] = 0;
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        dx = pt_x[i] - pt_x[j];
        dy = pt_y[i] - pt_y[j];
        dz = pt_z[i] - pt_z[j];
        dsq = dx * dx + dy * dy + dz * dz;
        if (dsq < join_thr) begin
          adj[i] |= 1 << j;
          adj[j] |= 1 << i;
        end
      end
    end
    full = (1 << n) - 1;
    indep = new[full + 1];
    cost = new[full + 1];
    indep[0] = 1'b1;
    cost[0] = 0;
    for (s = 1; s <= full; s++) begin
      lo = lowest_bit(s);
      indep[s] = indep[s & ~(1 << lo)] && ((adj[lo] & s) == 0);
    end
    for (s = 1; s <= full; s++) begin
      if (indep[s]) begin
        cost[s] = 1;
      end else begin
        // One colour class always holds the lowest vertex of the subset.
        lo = lowest_bit(s);
        bit_lo = 1 << lo;
        pool = s & ~bit_lo & ~adj[lo];
        best = 1 + cost[s & ~bit_lo];
        sub = pool;
        while (sub != 0) begin
          part = sub | bit_lo;
          if (indep[part]) begin
            c = 1 + cost[s & ~part];
            if (c < best) best = c;
          end
          sub = (sub - 1) & pool;
        end
        cost[s] = best;
      end
    end
    return cost[full];
  endfunction

  function automatic void predict_point(udgcn_in_t p);
    udgcn_out_t res;
    if (pt_count < MAX_PTS) begin
      pt_x[pt_count] = p.coord_x;
      pt_y[pt_count] = p.coord_y;
      pt_z[pt_count] = p.coord_z;
      pt_count++;
    end else begin
      pts_lost = 1'b1;
    end
    if (p.last_point) begin
      res.colour_count = (pt_count > 0) ? COST_W'(min_colours(pt_count)) : '0;
      res.points_dropped = pts_lost;
      colour_q = {colour_q, res};
      pt_count = 0;
      pts_lost = 1'b0;
    end
  endfunction

  task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z, logic last);
    udgcn_in_t   p;
    int unsigned gap;
    bit          taken;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    p.last_point = last;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    predict_point(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    bit taken;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    join_thr = v;
  endtask

  function automatic logic signed [COORD_W-1:0] near_coord();
    return COORD_W'($urandom_range(0, 2047)) - COORD_W'(1024);
  endfunction

  function automatic logic signed [COORD_W-1:0] any_coord();
    return COORD_W'($urandom());
  endfunction

  task automatic send_cluster_set(int unsigned n, bit wide);
    for (int i = 0; i < n; i++) begin
      if (wide)
        send_point(any_coord(), any_coord(), any_coord(), i == n - 1);
      else
        send_point(near_coord(), near_coord(), near_coord(), i == n - 1);
    end
  endtask

  task automatic test_directed();
    localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
    // Single point, then a coincident pair, then a distant pair.
    send_point(0, 0, 0, 1'b1);
    send_point(100, -100, 5, 1'b0);
    send_point(100, -100, 5, 1'b1);
    send_point(0, 0, 0, 1'b0);
    send_point(CMAX, 0, 0, 1'b1);
    // Triangle within the default distance, plus one far vertex.
    send_point(0, 0, 0, 1'b0);
    send_point(256, 0, 0, 1'b0);
    send_point(0, 256, 0, 1'b0);
    send_point(CMIN, CMIN, CMIN, 1'b1);
    // Opposite corners are joined at the widest threshold.
    write_threshold(THR_MAX);
    send_point(CMAX, CMAX, CMAX, 1'b0);
    send_point(CMIN, CMIN, CMIN, 1'b1);
    send_point(CMAX, CMIN, CMAX, 1'b0);
    send_point(CMIN, CMAX, CMIN, 1'b0);
    send_point(0, 0, 0, 1'b1);
    // A zero threshold joins nothing, not even coincident points.
    write_threshold('0);
    send_point(7, 7, 7, 1'b0);
    send_point(7, 7, 7, 1'b0);
    send_point(7, 7, 7, 1'b1);
    write_threshold(THR_RESET);
  endtask

  task automatic test_store_full();
    // Complete graph on the full store; the one surplus point, the last one, is lost.
    write_threshold(THR_MAX);
    for (int i = 0; i <= MAX_PTS; i++)
      send_point(any_coord(), any_coord(), any_coord(), i == MAX_PTS);
    // The next set must start clean.
    send_point(1, 2, 3, 1'b0);
    send_point(1, 2, 3, 1'b1);
    write_threshold(THR_RESET);
  endtask

  task automatic test_random_sets();
    int unsigned sent, n, r;
    logic [THR_W-1:0] thr_pick[6];
    thr_pick[0] = THR_RESET;
    thr_pick[1] = 52'd262144;
    thr_pick[2] = 52'd2000000;
    thr_pick[3] = '0;
    thr_pick[4] = THR_MAX;
    thr_pick[5] = THR_W'({$urandom(), $urandom()});
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_threshold(thr_pick[phase]);
      while (sent < (phase + 1) * 280) begin
        r = $urandom_range(0, 9);
        if (r < 7) n = $urandom_range(1, 5);
        else if (r < 9) n = $urandom_range(6, 7);
        else n = 8;
        send_cluster_set(n, $urandom_range(0, 7) == 0);
        sent += n;
      end
    end
    write_threshold(THR_RESET);
  endtask

  task automatic test_output_stall();
    drain_results();
    hold_req = 1'b1;
    for (int i = 0; i < 4; i++) send_cluster_set($urandom_range(2, 4), 1'b0);
  endtask

  // Result side: random stalls, one long hold-off on request, checks at mid-cycle.
  initial begin
    int unsigned stall_left, hold_left;
    udgcn_out_t  want;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (colour_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("Unexpected result transfer: %p", out_data);
        end else begin
          want = colour_q.pop_front();
          if (out_data.colour_count !== want.colour_count ||
              out_data.points_dropped !== want.points_dropped) begin
            err_count++;
            if (err_count <= 10)
              $display("Result mismatch: colours exp %0d got %0d, dropped exp %0b got %0b",
                       want.colour_count, out_data.colour_count,
                       want.points_dropped, out_data.points_dropped);
          end
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random_sets();
    test_output_stall();
    drain_results();
    repeat (50) @(posedge clk);
    if (err_count == 0 && colour_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
